// ===== sv/rcpl_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpl_pkg
// Shared types, codes and constants of the RC pulse light mode switch.
// ----------------------------------------------------------------------------
package rcpl_pkg;

  // Field widths
  localparam int PULSE_WIDTH = 15;
  localparam int STAMP_WIDTH = 32;
  localparam int MODE_WIDTH  = 3;
  localparam int LEVEL_WIDTH = 2;
  localparam int DUTY_WIDTH  = 8;
  localparam int MS_WIDTH    = 16;

  // Internal time arithmetic is modulo 2^TIME_WIDTH (16 to 64)
  localparam int TIME_WIDTH = 32;

  // Configuration port
  localparam int ADDR_WIDTH = 5;
  localparam int DATA_WIDTH = 32;
  localparam int REG_IDX_WIDTH = 3;

  typedef logic [PULSE_WIDTH-1:0] pulse_t;
  typedef logic [STAMP_WIDTH-1:0] stamp_t;
  typedef logic [TIME_WIDTH-1:0]  time_t;
  typedef logic [MODE_WIDTH-1:0]  mode_t;
  typedef logic [LEVEL_WIDTH-1:0] level_t;
  typedef logic [DUTY_WIDTH-1:0]  duty_t;
  typedef logic [MS_WIDTH-1:0]    ms_t;

  // Register indexes
  localparam logic [REG_IDX_WIDTH-1:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_SPECIAL_WIN  = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_LOW_THRESH   = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_MID_THRESH   = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_HIGH_THRESH  = 3'd4;
  localparam logic [REG_IDX_WIDTH-1:0] REG_DUTY_DIM     = 3'd5;
  localparam logic [REG_IDX_WIDTH-1:0] REG_DUTY_BRIGHT  = 3'd6;
  localparam logic [REG_IDX_WIDTH-1:0] REG_DUTY_SPECIAL = 3'd7;

  // Reset values
  localparam ms_t    RST_DEBOUNCE     = 16'd50;
  localparam ms_t    RST_SPECIAL_WIN  = 16'd1000;
  localparam pulse_t RST_LOW_THRESH   = 15'd1200;
  localparam pulse_t RST_MID_THRESH   = 15'd1500;
  localparam pulse_t RST_HIGH_THRESH  = 15'd1750;
  localparam duty_t  RST_DUTY_DIM     = 8'd160;
  localparam duty_t  RST_DUTY_BRIGHT  = 8'd255;
  localparam duty_t  RST_DUTY_SPECIAL = 8'd100;

  // Modes
  localparam mode_t MODE_UNSET   = 3'd0;
  localparam mode_t MODE_OFF     = 3'd1;
  localparam mode_t MODE_DIM     = 3'd2;
  localparam mode_t MODE_BRIGHT  = 3'd3;
  localparam mode_t MODE_SPECIAL = 3'd4;

  // Levels
  localparam level_t LEVEL_NONE = 2'd0;
  localparam level_t LEVEL_LOW  = 2'd1;
  localparam level_t LEVEL_MID  = 2'd2;
  localparam level_t LEVEL_HIGH = 2'd3;

  typedef struct packed {
    ms_t    debounce_ms;
    ms_t    special_window_ms;
    pulse_t low_threshold_us;
    pulse_t mid_threshold_us;
    pulse_t high_threshold_us;
    duty_t  duty_dim;
    duty_t  duty_bright;
    duty_t  duty_special;
  } cfg_t;

  typedef struct packed {
    mode_t mode;
    duty_t duty;
    logic  drive_update;
  } result_t;

endpackage

// ===== sv/rcpl_if.sv =====
// ----------------------------------------------------------------------------
// rcpl_if
// Valid/ready channels for pulse measurements and mode results.
// ----------------------------------------------------------------------------
interface rcpl_pulse_if;
  logic             valid;
  logic             ready;
  rcpl_pkg::pulse_t pulse_width_us;
  rcpl_pkg::stamp_t now_ms;

  modport source (output valid, output pulse_width_us, output now_ms, input ready);
  modport sink   (input valid, input pulse_width_us, input now_ms, output ready);
endinterface

interface rcpl_mode_if;
  logic            valid;
  logic            ready;
  rcpl_pkg::mode_t mode;
  rcpl_pkg::duty_t duty;
  logic            drive_update;

  modport source (output valid, output mode, output duty, output drive_update, input ready);
  modport sink   (input valid, input mode, input duty, input drive_update, output ready);
endinterface

// ===== sv/rcpl_regs.sv =====
// ----------------------------------------------------------------------------
// rcpl_regs
// APB-style configuration registers: thresholds, timings and duties.
// ----------------------------------------------------------------------------
module rcpl_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rcpl_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [rcpl_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [rcpl_pkg::DATA_WIDTH-1:0] prdata,
  output logic                            pready,
  output rcpl_pkg::cfg_t                  cfg
);

  logic                               wr_en;
  logic [rcpl_pkg::REG_IDX_WIDTH-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[rcpl_pkg::ADDR_WIDTH-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms       <= rcpl_pkg::RST_DEBOUNCE;
      cfg.special_window_ms <= rcpl_pkg::RST_SPECIAL_WIN;
      cfg.low_threshold_us  <= rcpl_pkg::RST_LOW_THRESH;
      cfg.mid_threshold_us  <= rcpl_pkg::RST_MID_THRESH;
      cfg.high_threshold_us <= rcpl_pkg::RST_HIGH_THRESH;
      cfg.duty_dim          <= rcpl_pkg::RST_DUTY_DIM;
      cfg.duty_bright       <= rcpl_pkg::RST_DUTY_BRIGHT;
      cfg.duty_special      <= rcpl_pkg::RST_DUTY_SPECIAL;
    end else if (wr_en) begin
      unique case (idx)
        rcpl_pkg::REG_DEBOUNCE:     cfg.debounce_ms       <= pwdata[rcpl_pkg::MS_WIDTH-1:0];
        rcpl_pkg::REG_SPECIAL_WIN:  cfg.special_window_ms <= pwdata[rcpl_pkg::MS_WIDTH-1:0];
        rcpl_pkg::REG_LOW_THRESH:   cfg.low_threshold_us  <= pwdata[rcpl_pkg::PULSE_WIDTH-1:0];
        rcpl_pkg::REG_MID_THRESH:   cfg.mid_threshold_us  <= pwdata[rcpl_pkg::PULSE_WIDTH-1:0];
        rcpl_pkg::REG_HIGH_THRESH:  cfg.high_threshold_us <= pwdata[rcpl_pkg::PULSE_WIDTH-1:0];
        rcpl_pkg::REG_DUTY_DIM:     cfg.duty_dim          <= pwdata[rcpl_pkg::DUTY_WIDTH-1:0];
        rcpl_pkg::REG_DUTY_BRIGHT:  cfg.duty_bright       <= pwdata[rcpl_pkg::DUTY_WIDTH-1:0];
        rcpl_pkg::REG_DUTY_SPECIAL: cfg.duty_special      <= pwdata[rcpl_pkg::DUTY_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rcpl_pkg::REG_DEBOUNCE:     prdata = rcpl_pkg::DATA_WIDTH'(cfg.debounce_ms);
      rcpl_pkg::REG_SPECIAL_WIN:  prdata = rcpl_pkg::DATA_WIDTH'(cfg.special_window_ms);
      rcpl_pkg::REG_LOW_THRESH:   prdata = rcpl_pkg::DATA_WIDTH'(cfg.low_threshold_us);
      rcpl_pkg::REG_MID_THRESH:   prdata = rcpl_pkg::DATA_WIDTH'(cfg.mid_threshold_us);
      rcpl_pkg::REG_HIGH_THRESH:  prdata = rcpl_pkg::DATA_WIDTH'(cfg.high_threshold_us);
      rcpl_pkg::REG_DUTY_DIM:     prdata = rcpl_pkg::DATA_WIDTH'(cfg.duty_dim);
      rcpl_pkg::REG_DUTY_BRIGHT:  prdata = rcpl_pkg::DATA_WIDTH'(cfg.duty_bright);
      rcpl_pkg::REG_DUTY_SPECIAL: prdata = rcpl_pkg::DATA_WIDTH'(cfg.duty_special);
      default:                    prdata = '0;
    endcase
  end

endmodule

// ===== sv/rcpl_engine.sv =====
// ----------------------------------------------------------------------------
// rcpl_engine
// Level classification, debounce and mode decision, with the mode state.
// ----------------------------------------------------------------------------
module rcpl_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  rcpl_pkg::pulse_t  pulse,
  input  rcpl_pkg::stamp_t  stamp,
  input  rcpl_pkg::cfg_t    cfg,
  output logic              produce,
  output rcpl_pkg::result_t result
);

  rcpl_pkg::mode_t  current_mode;
  rcpl_pkg::level_t previous_level;
  rcpl_pkg::level_t active_level;
  rcpl_pkg::time_t  mode_change_time;
  rcpl_pkg::time_t  debounce_start_time;

  rcpl_pkg::time_t  now;
  rcpl_pkg::level_t level;
  rcpl_pkg::time_t  debounce_start_next;
  rcpl_pkg::time_t  held;
  rcpl_pkg::time_t  since_change;
  rcpl_pkg::mode_t  mode_next;
  logic             fast;
  logic             history;
  logic             unlocked;

  assign now = rcpl_pkg::time_t'(stamp);

  // Comparisons tested in order; with disordered thresholds a pulse takes the first range that matches, else none
  always_comb begin
    if (pulse >= cfg.low_threshold_us && pulse < cfg.mid_threshold_us) begin
      level = rcpl_pkg::LEVEL_LOW;
    end else if (pulse >= cfg.mid_threshold_us && pulse < cfg.high_threshold_us) begin
      level = rcpl_pkg::LEVEL_MID;
    end else if (pulse >= cfg.high_threshold_us) begin
      level = rcpl_pkg::LEVEL_HIGH;
    end else begin
      level = rcpl_pkg::LEVEL_NONE;
    end
  end

  assign debounce_start_next = (level != previous_level) ? now : debounce_start_time;
  assign held         = now - debounce_start_next;
  assign since_change = now - mode_change_time;

  assign produce = (held > rcpl_pkg::time_t'(cfg.debounce_ms)) &&
                   (rcpl_pkg::mode_t'(level) != current_mode) &&
                   (level != active_level);

  // Zero change time means no change yet
  assign fast     = (mode_change_time != '0) &&
                    (since_change < rcpl_pkg::time_t'(cfg.special_window_ms));
  assign history  = (active_level == rcpl_pkg::LEVEL_LOW) && (level == rcpl_pkg::LEVEL_MID);
  assign unlocked = (current_mode != rcpl_pkg::MODE_SPECIAL);

  assign mode_next = (fast && history && unlocked) ? rcpl_pkg::MODE_SPECIAL
                                                   : rcpl_pkg::mode_t'(level);

  always_comb begin
    result.mode         = mode_next;
    result.drive_update = 1'b1;
    case (mode_next)
      rcpl_pkg::MODE_OFF:     result.duty = '0;
      rcpl_pkg::MODE_DIM:     result.duty = cfg.duty_dim;
      rcpl_pkg::MODE_BRIGHT:  result.duty = cfg.duty_bright;
      rcpl_pkg::MODE_SPECIAL: result.duty = cfg.duty_special;
      default: begin
        result.duty         = '0;
        result.drive_update = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode        <= rcpl_pkg::MODE_UNSET;
      previous_level      <= rcpl_pkg::LEVEL_NONE;
      active_level        <= rcpl_pkg::LEVEL_NONE;
      mode_change_time    <= '0;
      debounce_start_time <= '0;
    end else if (fire) begin
      previous_level      <= level;
      debounce_start_time <= debounce_start_next;
      if (produce) begin
        current_mode     <= mode_next;
        mode_change_time <= now;
        active_level     <= level;
      end
    end
  end

endmodule

// ===== sv/rc_pulse_light_mode_switch_unit.sv =====
// ----------------------------------------------------------------------------
// rc_pulse_light_mode_switch_unit
// Receiver pulse to light mode switch: debounced mode changes with duties.
// ----------------------------------------------------------------------------
// Each pulse transaction carries a measured pulse width (us) and a ms
// timestamp. It is classified into a level, debounced against the time the
// level last changed, and when it yields a new mode a single result
// transaction (mode, duty, drive_update) follows; otherwise nothing is
// emitted. One transaction is accepted per clock unless stalled: the
// measurement is held in an input register while the classify/compare/
// subtract logic decides, and the result lands in an output register.
// The only stall is a result held in the output register while the
// downstream sink is not ready. Config registers sit on an APB-style port
// (byte addresses 0..28, pready tied high) and should be written only while
// the block is idle.
module rc_pulse_light_mode_switch_unit (
  input  logic                            clk,
  input  logic                            rst,
  rcpl_pulse_if.sink                      pulse_in,
  rcpl_mode_if.source                     mode_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rcpl_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [rcpl_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [rcpl_pkg::DATA_WIDTH-1:0] prdata,
  output logic                            pready
);

  rcpl_pkg::cfg_t    cfg;

  // Input register
  logic              in_valid;
  rcpl_pkg::pulse_t  in_pulse;
  rcpl_pkg::stamp_t  in_stamp;

  // Decision
  logic              advance;
  logic              fire;
  logic              produce;
  rcpl_pkg::result_t result;

  // Output register
  logic              out_valid;
  logic              out_valid_next;
  rcpl_pkg::result_t out_result;

  rcpl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The decision stage moves on whenever the output register is free or
  // being emptied this cycle; at most one result per measurement.
  assign advance        = !out_valid || mode_out.ready;
  assign fire           = in_valid && advance;
  assign pulse_in.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pulse_in.ready) begin
      in_valid <= pulse_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pulse_in.valid && pulse_in.ready) begin
      in_pulse <= pulse_in.pulse_width_us;
      in_stamp <= pulse_in.now_ms;
    end
  end

  rcpl_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .pulse   (in_pulse),
    .stamp   (in_stamp),
    .cfg     (cfg),
    .produce (produce),
    .result  (result)
  );

  always_comb begin
    if (fire) begin
      out_valid_next = produce;
    end else if (mode_out.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produce) begin
      out_result <= result;
    end
  end

  assign mode_out.valid        = out_valid;
  assign mode_out.mode         = out_result.mode;
  assign mode_out.duty         = out_result.duty;
  assign mode_out.drive_update = out_result.drive_update;

  // A full input register that cannot advance must refuse new transactions
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |-> !pulse_in.ready)
    else $error("pulse accepted while decision stage stalled");

  // A produced result must show up on the output the next cycle
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    (fire && produce) |=> mode_out.valid)
    else $error("produced result lost");

  // drive_update flags every mode but unset
  a_drive_flag: assert property (@(posedge clk) disable iff (rst)
    mode_out.valid |-> (mode_out.drive_update == (mode_out.mode != rcpl_pkg::MODE_UNSET)))
    else $error("drive_update inconsistent with mode");

  // Off and unset never drive a non-zero duty
  a_off_duty: assert property (@(posedge clk) disable iff (rst)
    (mode_out.valid && (mode_out.mode == rcpl_pkg::MODE_OFF ||
                        mode_out.mode == rcpl_pkg::MODE_UNSET)) |-> (mode_out.duty == '0))
    else $error("non-zero duty for off or unset mode");

endmodule
